/* hw/rtl/dfmt_pkg.sv */
// Shared types, constants and helpers for the decimal field formatter.
// No dependencies; used by dfmt_bcd_conv and decimal_field_formatter_top.
`default_nettype none

package dfmt_pkg;

  localparam int unsigned BinWidth  = 32;
  localparam int unsigned CodeWidth = 6;

  localparam logic [CodeWidth-1:0] CodeSpace = 6'h20;
  localparam logic [CodeWidth-1:0] CodeZero  = 6'h30;

  localparam logic [7:0] GlyphNarrow = 8'd6;
  localparam logic [7:0] GlyphWide   = 8'd8;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_status_t;

  // double-dabble correction of one BCD digit
  function automatic logic [3:0] add3(input logic [3:0] d);
    add3 = (d >= 4'd5) ? 4'(d + 4'd3) : d;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/dfmt_bcd_conv.sv */
// Iterative binary-to-BCD converter (shift and add-3), one bit per cycle.
// Depends on dfmt_pkg.
`default_nettype none

module dfmt_bcd_conv #(
  parameter int unsigned NumDigits = 10
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start_i,
  input  wire  [dfmt_pkg::BinWidth-1:0] value_i,
  output logic [3:0]                  digits_o [NumDigits],
  output dfmt_pkg::conv_status_t      status_o
);
  import dfmt_pkg::*;

  localparam int unsigned BcdWidth = 4 * NumDigits;
  localparam int unsigned CntWidth = $clog2(BinWidth);

  logic [BinWidth-1:0] bin_q, bin_d;
  logic [BcdWidth-1:0] bcd_q, bcd_d, bcd_adj;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[4*i +: 4] = add3(bcd_q[4*i +: 4]);
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = value_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {bcd_adj[BcdWidth-2:0], bin_q[BinWidth-1]};
      bin_d = {bin_q[BinWidth-2:0], 1'b0};
      cnt_d = CntWidth'(cnt_q + 1'b1);
      if (cnt_q == CntWidth'(BinWidth - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  for (genvar g = 0; g < NumDigits; g++) begin : g_dig
    assign digits_o[g] = bcd_q[4*g +: 4];
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

`ifndef NO_ASSERTIONS
  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && cnt_q == '0)
    else $error("converter did not start");
  a_done_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("done without a finished conversion");
  a_digits_bcd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> digits_o[0] <= 4'd9)
    else $error("low digit out of BCD range");
`endif

endmodule

`default_nettype wire

/* hw/rtl/decimal_field_formatter_top.sv */
// Decimal field formatter top: sequencer and output register around the BCD unit.
// Depends on dfmt_pkg and dfmt_bcd_conv.
//
// Usage:
//   s_axis carries one field request: tdata = {start_row, start_column,
//   digit_count, number} from the high bit down, tuser = font_tall.
//   m_axis carries one character per digit position, most significant first:
//   tdata = {row, column, char_code} from the high bit down, tlast on the final
//   character. Leading zeros are sent as spaces; the last digit always shows.
//   A digit_count of zero is taken and gives no characters; counts above
//   MAX_DIGITS are clamped.
// Timing: the request is taken, then the conversion runs one bit per cycle
//   through the shift/add-3 unit, and the characters follow at one per cycle
//   while the receiver does not stall. s_axis_tready is high only while no
//   request is in progress.
// Reset clears the sequencer and drops m_axis_tvalid. When the receiver stalls,
//   the pending character holds in the output register and emission waits.
`default_nettype none

module decimal_field_formatter_top #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // number[31:0], digit_count[35:32], start_column[43:36], start_row[51:44]
  input  wire  [55:0] s_axis_tdata_i,
  // font_tall[0]
  input  wire         s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  // char_code[5:0], column[13:6], row[21:14]
  output logic [23:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);
  import dfmt_pkg::*;

  localparam int unsigned IdxWidth = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  state_e              state_q, state_d;
  logic [3:0]          rem_q, rem_d;
  logic [7:0]          col_q, col_d;
  logic [7:0]          row_q, row_d;
  logic                wide_q, wide_d;
  logic                shown_q, shown_d;
  logic                mvalid_q, mvalid_d;
  logic [CodeWidth-1:0] code_q, code_d;
  logic [7:0]          ocol_q, ocol_d;
  logic [7:0]          orow_q, orow_d;
  logic                olast_q, olast_d;

  logic                s_fire;
  logic                emit;
  logic [3:0]          cnt_in;
  logic [3:0]          digit;
  logic                is_last;
  logic [3:0]          digits [MAX_DIGITS];
  conv_status_t        conv_status;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_in = (s_axis_tdata_i[35:32] > 4'(MAX_DIGITS)) ? 4'(MAX_DIGITS)
                                                           : s_axis_tdata_i[35:32];

  dfmt_bcd_conv #(
    .NumDigits(MAX_DIGITS)
  ) u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s_fire && cnt_in != 4'd0),
    .value_i (s_axis_tdata_i[31:0]),
    .digits_o(digits),
    .status_o(conv_status)
  );

  assign emit    = (state_q == ST_EMIT) && (!mvalid_q || m_axis_tready_i);
  assign digit   = digits[rem_q[IdxWidth-1:0]];
  assign is_last = (rem_q == 4'd0);

  always_comb begin
    state_d  = state_q;
    rem_d    = rem_q;
    col_d    = col_q;
    row_d    = row_q;
    wide_d   = wide_q;
    shown_d  = shown_q;
    mvalid_d = mvalid_q && !m_axis_tready_i;
    code_d   = code_q;
    ocol_d   = ocol_q;
    orow_d   = orow_q;
    olast_d  = olast_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire && cnt_in != 4'd0) begin
          rem_d   = 4'(cnt_in - 4'd1);
          col_d   = s_axis_tdata_i[43:36];
          row_d   = s_axis_tdata_i[51:44];
          wide_d  = s_axis_tuser_i;
          shown_d = 1'b0;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_status.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          if (!shown_q && !is_last && digit == 4'd0) begin
            code_d = CodeSpace;
          end else begin
            code_d  = CodeZero + {2'b00, digit};
            shown_d = 1'b1;
          end
          mvalid_d = 1'b1;
          ocol_d   = col_q;
          orow_d   = row_q;
          olast_d  = is_last;
          col_d    = col_q + (wide_q ? GlyphWide : GlyphNarrow);
          rem_d    = 4'(rem_q - 4'd1);
          if (is_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mvalid_q <= 1'b0;
      rem_q    <= '0;
      shown_q  <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
      wide_q   <= 1'b0;
      code_q   <= '0;
      ocol_q   <= '0;
      orow_q   <= '0;
      olast_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      mvalid_q <= mvalid_d;
      rem_q    <= rem_d;
      shown_q  <= shown_d;
      col_q    <= col_d;
      row_q    <= row_d;
      wide_q   <= wide_d;
      code_q   <= code_d;
      ocol_q   <= ocol_d;
      orow_q   <= orow_d;
      olast_q  <= olast_d;
    end
  end

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = {2'b00, orow_q, ocol_q, code_q};
  assign m_axis_tlast_o  = olast_q;

`ifndef NO_ASSERTIONS
  a_done_in_conv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_status.done |-> state_q == ST_CONV)
    else $error("conversion finished outside CONV");
  a_zero_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && cnt_in == 4'd0 |=> state_q == ST_IDLE && !conv_status.busy)
    else $error("empty field started work");
  a_code_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> code_q == CodeSpace ||
      (code_q >= CodeZero && code_q <= CodeZero + 6'd9))
    else $error("character code out of range");
  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> rem_q < 4'(MAX_DIGITS))
    else $error("digit index beyond field");
  a_last_space : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> code_q != CodeSpace)
    else $error("last character blanked");
`endif

endmodule

`default_nettype wire
